/* src/assert_macros.svh */
// Assertion helpers shared by the RTL; all sample on clk_i, off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge.
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be true.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* src/rhh_pkg.sv */
package rhh_pkg;

  // Table geometry
  localparam int TableSize = 1024;
  localparam int MaxProbe  = 64;

  localparam int KeyW  = 32;
  localparam int ValW  = 64;
  localparam int DistW = 6;
  localparam int StatW = 3;

  localparam int IdxW = $clog2(TableSize);
  localparam int CntW = $clog2(TableSize + 1);
  localparam int KW   = $clog2(MaxProbe + 1);

  // Home slot hash multiplier
  localparam int HashMult = 33;
  // Inserts are refused once the table holds this many entries
  localparam int LoadLimit = TableSize - (TableSize + 9) / 10;
  localparam bit SizeIsPow2 = ((1 << IdxW) == TableSize);

  typedef enum logic {
    CmdInsert = 1'b0,
    CmdFind   = 1'b1
  } rhh_cmd_e;

  typedef enum logic [StatW-1:0] {
    StInserted = 3'd0,
    StFound    = 3'd1,
    StNotFound = 3'd2,
    StFull     = 3'd3,
    StOverflow = 3'd4
  } rhh_status_e;

  // One slot of the table as stored in RAM
  typedef struct packed {
    logic             occ;
    logic [DistW-1:0] probe_dist;
    logic [KeyW-1:0]  key;
    logic [ValW-1:0]  value;
  } rhh_entry_t;

  typedef struct packed {
    logic            start;
    logic [KeyW-1:0] key;
  } rhh_home_req_t;

  typedef struct packed {
    logic            done;
    logic [IdxW-1:0] idx;
  } rhh_home_rsp_t;

endpackage

/* src/rhh_ram.sv */
module rhh_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/rhh_home.sv */
module rhh_home (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rhh_pkg::rhh_home_req_t req_i,
  output rhh_pkg::rhh_home_rsp_t rsp_o
);
  import rhh_pkg::*;

  localparam int StepW = $clog2(KeyW);
  localparam logic [IdxW:0] SizeW = (IdxW + 1)'(TableSize);

  logic             busy_q;
  logic [StepW-1:0] cnt_q;
  logic [KeyW-1:0]  prod_q;
  logic [IdxW-1:0]  rem_q;
  logic [IdxW:0]    rem_step;
  logic [IdxW:0]    rem_next;
  logic             last;

  // Restoring remainder, one product bit per cycle (skipped for power-of-two sizes)
  assign rem_step = {rem_q, prod_q[KeyW-1]};
  assign rem_next = (rem_step >= SizeW) ? (rem_step - SizeW) : rem_step;
  assign last     = SizeIsPow2 || (cnt_q == StepW'(KeyW - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (last) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Datapath: product and partial remainder
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      prod_q <= KeyW'(req_i.key * KeyW'(HashMult));
      rem_q  <= '0;
    end else if (busy_q) begin
      prod_q <= {prod_q[KeyW-2:0], 1'b0};
      rem_q  <= rem_next[IdxW-1:0];
    end
  end

  assign rsp_o.done = busy_q && last;
  assign rsp_o.idx  = SizeIsPow2 ? prod_q[IdxW-1:0] : rem_next[IdxW-1:0];

endmodule

/* src/robin_hood_hash_table_unit.sv */
// Robin Hood hash table: 32-bit keys, 64-bit values, linear probing.
// Input channel (in_valid_i / in_stall_o) carries one request: command_i
// (insert or find), key_i and value_i. A request is taken when valid is high
// and stall is low. Output channel (out_valid_o / out_stall_i) returns one
// result per request: status_o and found_value_o (zero unless found).
// Steps: the key is hashed to its home slot, the slots are probed one by one,
// then the result moves to the output register; a refused insert skips the
// hash and the probe. With a table size that is not a power of two the hash
// is a restoring remainder over the product bits instead of a bit slice.
// The probe loop shares a single slot RAM (one read, one write per cycle),
// so requests are handled one at a time; stall stays high until the result
// is in the output register. After reset the block runs a clearing pass
// over all slots (TableSize of them, 1024 by default) with stall held high.
// A finished result waits in the output register while out_stall_i is high;
// the next request can be taken meanwhile, but its result is held back until
// the output register is free.
module robin_hood_hash_table_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      command_i,
  input  logic [rhh_pkg::KeyW-1:0]  key_i,
  input  logic [rhh_pkg::ValW-1:0]  value_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [rhh_pkg::StatW-1:0] status_o,
  output logic [rhh_pkg::ValW-1:0]  found_value_o
);
  import rhh_pkg::*;

`include "assert_macros.svh"

  typedef enum logic [2:0] {
    Clear,
    Idle,
    Hash,
    Eval,
    Done
  } state_e;

  state_e          state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d, idx_next;
  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q, out_valid_d;
  rhh_status_e     out_status_q, out_status_d;
  logic [ValW-1:0] out_value_q, out_value_d;

  rhh_cmd_e        cmd_q, cmd_d;
  logic [KeyW-1:0] key_q, key_d;
  logic [ValW-1:0] val_q, val_d;
  logic [KW-1:0]   k_q, k_d, k_inc;
  rhh_status_e     res_status_q, res_status_d;
  logic [ValW-1:0] res_value_q, res_value_d;

  logic            accept;
  rhh_home_req_t   home_req;
  rhh_home_rsp_t   home_rsp;
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  rhh_entry_t      ram_wdata, slot;
  logic            k_gt_dist;

  assign in_stall_o = (state_q != Idle);
  assign accept     = in_valid_i && !in_stall_o;

  assign home_req.start = accept && !((command_i == CmdInsert) &&
                                      (count_q >= CntW'(LoadLimit)));
  assign home_req.key   = key_i;

  rhh_home u_home (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (home_req),
    .rsp_o  (home_rsp)
  );

  rhh_ram #(
    .Width ($bits(rhh_entry_t)),
    .Depth (TableSize)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (slot)
  );

  // Probe helpers
  assign idx_next  = (idx_q == IdxW'(TableSize - 1)) ? '0 : idx_q + 1'b1;
  assign ram_raddr = (state_q == Hash) ? home_rsp.idx : idx_next;
  assign k_gt_dist = (k_q > KW'(slot.probe_dist));
  assign k_inc     = k_q + 1'b1;

  // Sequencer
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    val_d        = val_q;
    k_d          = k_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    ram_we       = 1'b0;
    ram_waddr    = idx_q;
    ram_wdata    = '{occ: 1'b1, probe_dist: k_q[DistW-1:0], key: key_q, value: val_q};

    case (state_q)
      Clear: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        idx_d     = idx_next;
        if (idx_q == IdxW'(TableSize - 1)) begin
          state_d = Idle;
        end
      end
      Idle: begin
        if (accept) begin
          cmd_d = rhh_cmd_e'(command_i);
          key_d = key_i;
          val_d = value_i;
          if (home_req.start) begin
            state_d = Hash;
          end else begin
            res_status_d = StFull;
            res_value_d  = '0;
            state_d      = Done;
          end
        end
      end
      Hash: begin
        if (home_rsp.done) begin
          idx_d   = home_rsp.idx;
          k_d     = '0;
          state_d = Eval;
        end
      end
      Eval: begin
        res_value_d = '0;
        idx_d       = idx_next;
        k_d         = k_inc;
        if (cmd_q == CmdInsert) begin
          if (!slot.occ) begin
            // Empty slot: settle the carried entry
            ram_we       = 1'b1;
            count_d      = count_q + 1'b1;
            res_status_d = StInserted;
            state_d      = Done;
          end else begin
            if (k_gt_dist) begin
              // Resident is richer: swap and carry it on
              ram_we = 1'b1;
              key_d  = slot.key;
              val_d  = slot.value;
              k_d    = KW'(slot.probe_dist) + 1'b1;
            end
            if (k_d == KW'(MaxProbe)) begin
              res_status_d = StOverflow;
              state_d      = Done;
            end
          end
        end else begin
          if (!slot.occ || k_gt_dist) begin
            res_status_d = StNotFound;
            state_d      = Done;
          end else if (slot.key == key_q) begin
            res_status_d = StFound;
            res_value_d  = slot.value;
            state_d      = Done;
          end else if (k_inc == KW'(MaxProbe)) begin
            res_status_d = StNotFound;
            state_d      = Done;
          end
        end
      end
      Done: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_value_d  = res_value_q;
          state_d      = Idle;
        end
      end
      default: begin
        state_d = Idle;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= Clear;
      idx_q        <= '0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= StInserted;
      out_value_q  <= '0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      count_q      <= count_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_value_q  <= out_value_d;
    end
  end

  // Carried entry and pending result
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    key_q        <= key_d;
    val_q        <= val_d;
    k_q          <= k_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign found_value_o = out_value_q;

  // Checks
  `ASSERT_NEVER(a_count_in_limit, count_q > CntW'(LoadLimit), "entry count above load limit")
  `ASSERT_PROP(a_count_step, count_q != $past(count_q) |-> count_q == $past(count_q) + 1'b1, "entry count jumped")
  `ASSERT_PROP(a_value_zero, out_valid_o && (status_o != StFound) |-> found_value_o == '0, "value without hit")
  `ASSERT_PROP(a_home_in_hash, home_rsp.done |-> state_q == Hash, "hash result outside hash state")
  `ASSERT_NEVER(a_write_state, ram_we && !(state_q == Clear || state_q == Eval), "slot write outside probe")

endmodule
